FILE: src/r4bm_pkg.sv
`default_nettype none

package r4bm_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 32;

  // Booth triples {y[2i+1], y[2i], y[2i-1]}
  localparam logic [2:0] TRIP_ZERO_LO = 3'b000;
  localparam logic [2:0] TRIP_POS_1A  = 3'b001;
  localparam logic [2:0] TRIP_POS_1B  = 3'b010;
  localparam logic [2:0] TRIP_POS_2   = 3'b011;
  localparam logic [2:0] TRIP_NEG_2   = 3'b100;
  localparam logic [2:0] TRIP_NEG_1A  = 3'b101;
  localparam logic [2:0] TRIP_NEG_1B  = 3'b110;
  localparam logic [2:0] TRIP_ZERO_HI = 3'b111;

  // Sign-extension prefix bits placed just above each row
  localparam logic [2:0] PFX_FIRST_POS = 3'b100;
  localparam logic [2:0] PFX_FIRST_NEG = 3'b011;
  localparam logic [2:0] PFX_REST_POS  = 3'b011;
  localparam logic [2:0] PFX_REST_NEG  = 3'b010;

  function automatic int unsigned tree_levels(input int unsigned width);
    return $clog2(width / 2 + 1);
  endfunction

  // row stage plus one register per adder-tree level
  function automatic int unsigned pipe_latency(input int unsigned width);
    return tree_levels(width) + 1;
  endfunction

endpackage

`default_nettype wire

FILE: src/radix4_booth_unsigned_multiplier_unit.sv
// Pipeline: a Booth recoding and row generation stage, then a registered stage for each
//   level of the adder tree.
// Throughput: one beat per cycle; a stalled output holds and only stages behind it
//   that are full back up, empty stages keep filling.
// Reset: synchronous, active low; clears the stage valid bits, data is not reset.
`default_nettype none

module radix4_booth_unsigned_multiplier_unit #(
  parameter int unsigned OPERAND_WIDTH = r4bm_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [OPERAND_WIDTH-1:0]     in_multiplicand,
  input  wire logic [OPERAND_WIDTH-1:0]     in_multiplier,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2*OPERAND_WIDTH-1:0]        out_product
);

  import r4bm_pkg::*;

  localparam int unsigned DIGITS  = OPERAND_WIDTH / 2 + 1;
  localparam int unsigned LEVELS  = tree_levels(OPERAND_WIDTH);
  localparam int unsigned ROWS_P2 = 2 ** LEVELS;
  localparam int unsigned PROD_W  = 2 * OPERAND_WIDTH;
  localparam int unsigned ROW_W   = OPERAND_WIDTH + 1;
  localparam int unsigned ROWX_W  = OPERAND_WIDTH + 4;
  localparam int unsigned EXT_W   = 2 * DIGITS + 1;

  logic [PROD_W-1:0] rows_nxt [ROWS_P2];
  logic [PROD_W-1:0] sum_r    [LEVELS+1][ROWS_P2];
  logic [LEVELS:0]   valid_r;
  logic [LEVELS:0]   adv;

  // stage k moves when it is empty or the stage after it moves
  always_comb begin
    adv[LEVELS] = !valid_r[LEVELS] || !out_stall;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0] || !rst_n;

  // Booth recoding and partial-product rows
  always_comb begin
    logic [EXT_W-1:0]  ext;
    logic [2:0]        trip;
    logic              neg;
    logic [ROW_W-1:0]  base;
    logic [2:0]        pfx;
    logic [ROWX_W-1:0] rowx;
    ext = EXT_W'({in_multiplier, 1'b0});
    for (int i = 0; i < ROWS_P2; i++) begin
      rows_nxt[i] = '0;
    end
    for (int i = 0; i < DIGITS; i++) begin
      trip = ext[2*i +: 3];
      neg  = (trip == TRIP_NEG_2) || (trip == TRIP_NEG_1A) || (trip == TRIP_NEG_1B);
      unique case (trip)
        TRIP_POS_1A, TRIP_POS_1B: base = {1'b0, in_multiplicand};
        TRIP_POS_2:               base = {in_multiplicand, 1'b0};
        TRIP_NEG_2:               base = ~{in_multiplicand, 1'b0};
        TRIP_NEG_1A, TRIP_NEG_1B: base = ~{1'b0, in_multiplicand};
        default:                  base = '0;
      endcase
      if (i == 0) begin
        pfx = neg ? PFX_FIRST_NEG : PFX_FIRST_POS;
      end else begin
        pfx = neg ? PFX_REST_NEG : PFX_REST_POS;
      end
      rowx        = {pfx, base} + ROWX_W'(neg);
      rows_nxt[i] = PROD_W'(rowx) << (2 * i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k <= LEVELS; k++) begin
        if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // registered pairwise adder tree; unused upper entries stay zero
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int j = 0; j < ROWS_P2; j++) begin
        sum_r[0][j] <= rows_nxt[j];
      end
    end
    for (int l = 1; l <= LEVELS; l++) begin
      if (adv[l]) begin
        for (int j = 0; j < ROWS_P2 / 2; j++) begin
          sum_r[l][j] <= sum_r[l-1][2*j] + sum_r[l-1][2*j+1];
        end
        for (int j = ROWS_P2 / 2; j < ROWS_P2; j++) begin
          sum_r[l][j] <= '0;
        end
      end
    end
  end

  assign out_valid   = valid_r[LEVELS];
  assign out_product = sum_r[LEVELS][0];

endmodule

`default_nettype wire

FILE: src/r4bm_checker.sv
`default_nettype none

module r4bm_checker #(
  parameter int unsigned OPERAND_WIDTH = r4bm_pkg::OPERAND_WIDTH_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [OPERAND_WIDTH-1:0]     in_multiplicand,
  input wire logic [OPERAND_WIDTH-1:0]     in_multiplier,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [2*OPERAND_WIDTH-1:0]   out_product
);

  import r4bm_pkg::*;

  localparam int unsigned LAT    = pipe_latency(OPERAND_WIDTH);
  localparam int unsigned CW     = $clog2(LAT + 1);
  localparam int unsigned PROD_W = 2 * OPERAND_WIDTH;

  logic [CW-1:0]     clean_cnt_r;
  logic [PROD_W-1:0] exp_product;
  logic              in_beat;

  assign in_beat     = in_valid && !in_stall;
  assign exp_product = PROD_W'(in_multiplicand) * PROD_W'(in_multiplier);

  // run of consecutive cycles without output stall since reset or the last stall, saturating at LAT
  always_ff @(posedge clk) begin
    if (!rst_n || out_stall) begin
      clean_cnt_r <= '0;
    end else if (clean_cnt_r != CW'(LAT)) begin
      clean_cnt_r <= clean_cnt_r + CW'(1);
    end
  end

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // sampled reset in the antecedent: the edge that releases reset still sees a stalled input
  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !out_valid |-> !in_stall)
    else $error("input stalled while pipeline output is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_product))
    else $error("stalled output beat changed");

  a_product: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_beat, LAT) && (clean_cnt_r >= CW'(LAT - 1))
    |-> out_valid && (out_product == $past(exp_product, LAT)))
    else $error("wrong or late product");

endmodule

bind radix4_booth_unsigned_multiplier_unit r4bm_checker #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_r4bm_checker (.*);

`default_nettype wire

FILE: tb/tb_radix4_booth_unsigned_multiplier_unit.sv
`timescale 1ns / 100ps

module tb_radix4_booth_unsigned_multiplier_unit;
  import r4bm_pkg::*;

  localparam int unsigned OPW         = OPERAND_WIDTH_DEF;
  localparam int unsigned PW          = 2 * OPW;
  localparam int unsigned DIGITS      = OPW / 2 + 1;
  localparam int unsigned RANDOM_BEATS = 1530;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef struct {
    logic [OPW-1:0] mcand;
    logic [OPW-1:0] mplier;
    logic [PW-1:0]  product;
  } product_rec_t;

  typedef struct {
    logic [OPW-1:0] mcand;
    logic [OPW-1:0] mplier;
    bit             typed;
    logic [PW-1:0]  product;
  } directed_row_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  logic [OPW-1:0] in_multiplicand;
  logic [OPW-1:0] in_multiplier;
  logic           out_valid;
  logic           out_stall;
  logic [PW-1:0]  out_product;

  // travels with each input beat: product typed into the table, if any
  bit             beat_typed;
  logic [PW-1:0]  beat_typed_product;

  product_rec_t   pending_products[$];
  int unsigned    fail_count;
  int unsigned    cycle_count;
  int unsigned    burst_left;

  radix4_booth_unsigned_multiplier_unit #(
    .OPERAND_WIDTH(OPW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_multiplicand(in_multiplicand),
    .in_multiplier(in_multiplier),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_product(out_product)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Booth sum: one row per overlapping triple of y, constant prefix bits in
  // place of sign extension, ones added at column 2i for negative rows.
  function automatic logic [PW-1:0] booth_product(input logic [OPW-1:0] x,
                                                  input logic [OPW-1:0] y);
    logic [OPW+2:0] ext;
    logic [2:0]     trip;
    logic [OPW:0]   row;
    logic [PW-1:0]  line;
    logic [PW-1:0]  acc;
    logic           neg;
    ext = {2'b00, y, 1'b0};
    acc = '0;
    for (int i = 0; i < DIGITS; i++) begin
      trip = ext[2*i +: 3];
      neg  = (trip == TRIP_NEG_2) || (trip == TRIP_NEG_1A) || (trip == TRIP_NEG_1B);
      case (trip)
        TRIP_POS_1A, TRIP_POS_1B: row = {1'b0, x};
        TRIP_POS_2:               row = {x, 1'b0};
        TRIP_NEG_2:               row = ~{x, 1'b0};
        TRIP_NEG_1A, TRIP_NEG_1B: row = ~{1'b0, x};
        default:                  row = '0;
      endcase
      line = PW'(row);
      if (i == 0)
        line = line | (PW'(neg ? PFX_FIRST_NEG : PFX_FIRST_POS) << (OPW + 1));
      else
        line = line | (PW'(neg ? PFX_REST_NEG : PFX_REST_POS) << (OPW + 1));
      if (neg)
        line = line + PW'(1);
      acc = acc + (line << (2 * i));
    end
    return acc;
  endfunction

  // mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 10);
    else
      return $urandom_range(20, 60);
  endfunction

  function automatic logic [OPW-1:0] pick_operand();
    int unsigned r;
    logic [OPW-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 50)
      v = $urandom;
    else if (r < 60)
      v = $urandom_range(0, 15);
    else if (r < 70)
      v = {OPW{1'b1}} >> $urandom_range(0, OPW - 1);
    else if (r < 78)
      v = OPW'(1) << $urandom_range(0, OPW - 1);
    else if (r < 86)
      v = $urandom & $urandom & $urandom;
    else if (r < 94)
      v = $urandom | $urandom | $urandom;
    else
      v = ($urandom_range(0, 1) != 0) ? {OPW{1'b1}} : {1'b1, (OPW-1)'($urandom)};
    return v;
  endfunction

  task automatic send_beat(input logic [OPW-1:0] a, input logic [OPW-1:0] b,
                           input bit typed, input logic [PW-1:0] typed_product);
    int unsigned gap;
    gap = 0;
    if (burst_left > 0)
      burst_left--;
    else begin
      gap = idle_len();
      if ($urandom_range(0, 99) < 3)
        burst_left = $urandom_range(30, 80);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_multiplicand    <= a;
    in_multiplier      <= b;
    beat_typed         <= typed;
    beat_typed_product <= typed_product;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // result side stalls: stall-free runs, some of them long, then a stall
  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(50, 200)) @(posedge clk);
      else
        repeat ($urandom_range(1, 8)) @(posedge clk);
      out_stall <= 1'b1;
      repeat (idle_len() + 1) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // both channels are sampled here, input first, so no beat races its result
  always @(posedge clk) begin
    product_rec_t rec;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        rec.mcand   = in_multiplicand;
        rec.mplier  = in_multiplier;
        rec.product = beat_typed ? beat_typed_product
                                 : booth_product(in_multiplicand, in_multiplier);
        pending_products.push_back(rec);
      end
      if (out_valid && !out_stall) begin
        if (pending_products.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("unexpected product beat: %h", out_product);
        end else begin
          rec = pending_products.pop_front();
          if (out_product !== rec.product) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
              $display("product mismatch: %h * %h expected %h got %h",
                       rec.mcand, rec.mplier, rec.product, out_product);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("radix4_booth_unsigned_multiplier_unit verification failed");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;

    rows = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 64'h0000_0000_0000_0000},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 64'h0000_0000_0000_0000},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 64'h0000_0000_0000_0000},
      '{32'h0000_0001, 32'h0000_0001, 1'b1, 64'h0000_0000_0000_0001},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 64'h0000_0000_FFFF_FFFF},
      '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 64'h0000_0000_FFFF_FFFF},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFE_0000_0001},
      '{32'h8000_0000, 32'h8000_0000, 1'b1, 64'h4000_0000_0000_0000},
      '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 64'h7FFF_FFFF_8000_0000},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 64'h3FFF_FFFF_0000_0001},
      '{32'h0000_0002, 32'h4000_0000, 1'b1, 64'h0000_0000_8000_0000},
      // multiplier patterns that walk every Booth triple
      '{32'h1234_5678, 32'h5555_5555, 1'b0, '0},
      '{32'h1234_5678, 32'hAAAA_AAAA, 1'b0, '0},
      '{32'hFEDC_BA98, 32'h3333_3333, 1'b0, '0},
      '{32'hFEDC_BA98, 32'hCCCC_CCCC, 1'b0, '0},
      '{32'h8765_4321, 32'h6666_6666, 1'b0, '0},
      '{32'h8765_4321, 32'h9999_9999, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'hDB6D_B6DB, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
      '{32'hDEAD_BEEF, 32'hFFFF_FFFE, 1'b0, '0},
      '{32'hFFFF_FFFE, 32'h8000_0001, 1'b0, '0}
    };

    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_multiplicand    <= '0;
    in_multiplier      <= '0;
    beat_typed         <= 1'b0;
    beat_typed_product <= '0;
    burst_left  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i])
      send_beat(rows[i].mcand, rows[i].mplier, rows[i].typed, rows[i].product);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      a = pick_operand();
      b = pick_operand();
      send_beat(a, b, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (pipe_latency(OPW) + 4) @(posedge clk);

    if (fail_count == 0 && pending_products.size() == 0)
      $display("radix4_booth_unsigned_multiplier_unit verification clean");
    else
      $display("radix4_booth_unsigned_multiplier_unit verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/r4bm_pkg.sv
src/radix4_booth_unsigned_multiplier_unit.sv
src/r4bm_checker.sv
tb/tb_radix4_booth_unsigned_multiplier_unit.sv
